// File: hw/rtl/terrain_alpha_shadow_map_decoder_macros.svh
// Assertion macros shared by the blend map decoder RTL.
// Needs clk_i and rst_ni in the scope of each use.
`ifndef TERRAIN_ALPHA_SHADOW_MAP_DECODER_MACROS_SVH
`define TERRAIN_ALPHA_SHADOW_MAP_DECODER_MACROS_SVH

// Same-cycle implication.
`define TASM_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define TASM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/tasm_pkg.sv
// Package for the blend map decoder: sizes, codes and queue entry types.
// No dependencies.
`timescale 1ns / 1ps

package tasm_pkg;

  localparam int unsigned MAP_PIXELS = 4096;
  localparam int unsigned POS_W      = $clog2(MAP_PIXELS + 1);
  localparam int unsigned IDX_W      = 12;
  localparam int unsigned QDEPTH     = 4;
  localparam int unsigned QPTR_W     = $clog2(QDEPTH);
  localparam int unsigned QCNT_W     = $clog2(QDEPTH + 1);

  localparam logic [7:0] FILL_FLAG   = 8'h80;
  localparam logic [7:0] COUNT_MASK  = 8'h7F;
  localparam logic [7:0] SHADOW_SET  = 8'd85;

  typedef enum logic [1:0] {
    FMT_RLE    = 2'd0,
    FMT_RAW    = 2'd1,
    FMT_NIBBLE = 2'd2,
    FMT_SHADOW = 2'd3
  } fmt_e;

  typedef enum logic [1:0] {
    KIND_RUN,
    KIND_NIBBLE,
    KIND_SHADOW
  } kind_e;

  typedef struct packed {
    logic [IDX_W-1:0] start;
    logic [7:0]       data;
    kind_e            kind;
    logic [6:0]       len;
    logic [2:0]       last_sub;
    logic             done;
  } job_t;

  typedef struct packed {
    logic valid;
    job_t job;
  } push_t;

  typedef struct packed {
    logic valid;
    job_t job;
  } head_t;

  typedef struct packed {
    logic [IDX_W-1:0] pixel_index;
    logic [7:0]       pixel_value;
    logic [6:0]       run_length;
    logic             map_done;
    logic             last_result;
  } res_t;

endpackage

// File: hw/rtl/tasm_ifs.sv
// Channel interfaces: input bytes, decoded runs, format register writes.
// No dependencies.
`timescale 1ns / 1ps

interface tasm_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       new_map;
  modport source (output valid, in_byte, new_map, input ready);
  modport sink   (input valid, in_byte, new_map, output ready);
endinterface

interface tasm_out_if;
  logic        valid;
  logic        ready;
  logic [11:0] pixel_index;
  logic [7:0]  pixel_value;
  logic [6:0]  run_length;
  logic        map_done;
  logic        last_result;
  modport source (output valid, pixel_index, pixel_value, run_length, map_done,
                  last_result, input ready);
  modport sink   (input valid, pixel_index, pixel_value, run_length, map_done,
                  last_result, output ready);
endinterface

interface tasm_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] map_format;
  modport source (output valid, map_format, input ready);
  modport sink   (input valid, map_format, output ready);
endinterface

// File: hw/rtl/tasm_front.sv
// Front end: accepts bytes, tracks map position and run-length header state,
// and pushes one job per byte that yields runs. Uses tasm_pkg, tasm_ifs.
`timescale 1ns / 1ps
`include "terrain_alpha_shadow_map_decoder_macros.svh"

module tasm_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  tasm_in_if.sink         in_i,
  tasm_cfg_if.sink        cfg_i,
  input  logic            q_full_i,
  output tasm_pkg::push_t push_o
);
  import tasm_pkg::*;

  fmt_e             fmt_q, fmt_d;
  logic [POS_W-1:0] pos_q, pos_d;
  logic             expect_q, expect_d;
  logic             fill_q, fill_d;
  logic [6:0]       rem_q, rem_d;

  logic [POS_W-1:0] pos_e, left;
  logic             expect_e, fill_e, full, accept;
  logic [6:0]       rem_e, nominal, adv, hdr_cnt;
  logic             hdr_fill;
  kind_e            kind;

  assign in_i.ready  = !q_full_i;
  assign cfg_i.ready = 1'b1;
  assign accept      = in_i.valid && !q_full_i;

  assign pos_e    = in_i.new_map ? '0 : pos_q;
  assign expect_e = in_i.new_map ? 1'b1 : expect_q;
  assign fill_e   = in_i.new_map ? 1'b0 : fill_q;
  assign rem_e    = in_i.new_map ? 7'd0 : rem_q;
  assign full     = pos_e >= POS_W'(MAP_PIXELS);
  assign left     = POS_W'(MAP_PIXELS) - pos_e;
  assign hdr_cnt  = 7'(in_i.in_byte & COUNT_MASK);
  assign hdr_fill = (in_i.in_byte & FILL_FLAG) != 8'd0;

  always_comb begin
    nominal  = 7'd0;
    kind     = KIND_RUN;
    expect_d = expect_e;
    fill_d   = fill_e;
    rem_d    = rem_e;
    unique case (fmt_q)
      FMT_RLE: begin
        if (expect_e) begin
          if (hdr_cnt != 7'd0 || hdr_fill) begin
            fill_d   = hdr_fill;
            rem_d    = hdr_cnt;
            expect_d = 1'b0;
          end
        end else if (fill_e) begin
          nominal  = rem_e;
          rem_d    = 7'd0;
          expect_d = 1'b1;
        end else begin
          nominal  = 7'd1;
          rem_d    = rem_e - 7'd1;
          expect_d = (rem_d == 7'd0);
        end
      end
      FMT_RAW: begin
        nominal = 7'd1;
      end
      FMT_NIBBLE: begin
        nominal = 7'd2;
        kind    = KIND_NIBBLE;
      end
      FMT_SHADOW: begin
        nominal = 7'd8;
        kind    = KIND_SHADOW;
      end
      default: begin
        nominal = 7'd0;
      end
    endcase
  end

  assign adv = (left < POS_W'(nominal)) ? 7'(left) : nominal;

  always_comb begin
    pos_d             = full ? pos_e : pos_e + POS_W'(adv);
    push_o.valid      = accept && !full && (adv != 7'd0);
    push_o.job.start  = IDX_W'(pos_e);
    push_o.job.data   = in_i.in_byte;
    push_o.job.kind   = kind;
    push_o.job.len    = adv;
    push_o.job.last_sub = (kind == KIND_RUN) ? 3'd0 : 3'(adv - 7'd1);
    push_o.job.done   = (POS_W'(adv) == left);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q    <= FMT_RLE;
      pos_q    <= '0;
      expect_q <= 1'b1;
      fill_q   <= 1'b0;
      rem_q    <= 7'd0;
    end else begin
      if (cfg_i.valid) begin
        fmt_q <= fmt_d;
      end
      if (accept) begin
        pos_q <= pos_d;
        if (!full) begin
          expect_q <= expect_d;
          fill_q   <= fill_d;
          rem_q    <= rem_d;
        end else begin
          expect_q <= expect_e;
          fill_q   <= fill_e;
          rem_q    <= rem_e;
        end
      end
    end
  end

  assign fmt_d = fmt_e'(cfg_i.map_format);

  `TASM_ASSERT(a_pos_bound, 1'b1, pos_q <= POS_W'(MAP_PIXELS), "map position past map end")

endmodule

// File: hw/rtl/tasm_queue.sv
// Job queue between front and back ends, four entries in flops.
// Uses tasm_pkg.
`timescale 1ns / 1ps
`include "terrain_alpha_shadow_map_decoder_macros.svh"

module tasm_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  tasm_pkg::push_t push_i,
  input  logic            pop_i,
  output logic            full_o,
  output tasm_pkg::head_t head_o
);
  import tasm_pkg::*;

  job_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_q, rd_q;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              do_pop;

  assign full_o       = (cnt_q == QCNT_W'(QDEPTH));
  assign head_o.valid = (cnt_q != '0);
  assign head_o.job   = mem_q[rd_q];
  assign do_pop       = pop_i && head_o.valid;

  always_comb begin
    cnt_d = cnt_q;
    if (push_i.valid && !do_pop) begin
      cnt_d = cnt_q + QCNT_W'(1);
    end else if (!push_i.valid && do_pop) begin
      cnt_d = cnt_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i.valid) begin
        wr_q <= wr_q + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_q <= rd_q + QPTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.valid) begin
      mem_q[wr_q] <= push_i.job;
    end
  end

  `TASM_ASSERT(a_cnt_bound, 1'b1, cnt_q <= QCNT_W'(QDEPTH), "queue count past depth")
  `TASM_ASSERT(a_no_overflow, full_o, !push_i.valid || do_pop, "push into full queue")
  `TASM_ASSERT_NEXT(a_cnt_up, push_i.valid && !do_pop, cnt_q == $past(cnt_q) + QCNT_W'(1), "count lost a push")

endmodule

// File: hw/rtl/tasm_back.sv
// Back end: expands the head job into runs behind an output register, one beat
// per cycle while the output is not stalled. Uses tasm_pkg, tasm_ifs.
`timescale 1ns / 1ps
`include "terrain_alpha_shadow_map_decoder_macros.svh"

module tasm_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  tasm_pkg::head_t head_i,
  output logic            pop_o,
  tasm_out_if.source      out_o
);
  import tasm_pkg::*;

  logic [2:0] sub_q;
  logic       out_valid_q;
  res_t       out_q, res_d;
  logic       load, last;
  logic [3:0] nib;

  assign load  = head_i.valid && (!out_valid_q || out_o.ready);
  assign last  = (sub_q == head_i.job.last_sub);
  assign pop_o = load && last;
  assign nib   = sub_q[0] ? head_i.job.data[7:4] : head_i.job.data[3:0];

  always_comb begin
    res_d.pixel_index = head_i.job.start + IDX_W'(sub_q);
    res_d.run_length  = 7'd1;
    res_d.map_done    = head_i.job.done && last;
    res_d.last_result = last;
    case (head_i.job.kind)
      KIND_RUN: begin
        res_d.pixel_value = head_i.job.data;
        res_d.run_length  = head_i.job.len;
      end
      KIND_NIBBLE: begin
        res_d.pixel_value = {nib, nib};
      end
      KIND_SHADOW: begin
        res_d.pixel_value = head_i.job.data[sub_q] ? SHADOW_SET : 8'd0;
      end
      default: begin
        res_d.pixel_value = head_i.job.data;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sub_q       <= 3'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        sub_q       <= last ? 3'd0 : sub_q + 3'd1;
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= res_d;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.pixel_index = out_q.pixel_index;
  assign out_o.pixel_value = out_q.pixel_value;
  assign out_o.run_length  = out_q.run_length;
  assign out_o.map_done    = out_q.map_done;
  assign out_o.last_result = out_q.last_result;

  `TASM_ASSERT(a_sub_bound, head_i.valid, sub_q <= head_i.job.last_sub, "beat index past job")
  `TASM_ASSERT(a_done_last, out_valid_q && out_q.map_done, out_q.last_result, "map done mid byte")

endmodule

// File: hw/rtl/terrain_alpha_shadow_map_decoder.sv
// Terrain blend map decoder top level: front end, job queue, back end.
// Uses tasm_pkg, tasm_ifs, tasm_front, tasm_queue, tasm_back.
//
//   port   dir  beat carries
//   in_i   in   in_byte, new_map
//   cfg_i  in   map_format
//   out_o  out  pixel_index, pixel_value, run_length, map_done, last_result
//
// A byte is taken each cycle while the four-entry job queue has room.
// The back end sends one run per cycle while out_o is not stalled: raw, copy and
// fill bytes yield one run, nibble bytes two, shadow bytes eight; that expansion sets the sustained rate.
// Bytes that yield no run (headers, full map) take no queue slot.
// Reset restores format run-length, position zero and header state.
// An output stall fills the queue, then drops in_i.ready.
`timescale 1ns / 1ps

module terrain_alpha_shadow_map_decoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  tasm_in_if.sink    in_i,
  tasm_cfg_if.sink   cfg_i,
  tasm_out_if.source out_o
);
  import tasm_pkg::*;

  push_t push;
  head_t head;
  logic  q_full, pop;

  tasm_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .cfg_i    (cfg_i),
    .q_full_i (q_full),
    .push_o   (push)
  );

  tasm_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .pop_i  (pop),
    .full_o (q_full),
    .head_o (head)
  );

  tasm_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .head_i (head),
    .pop_o  (pop),
    .out_o  (out_o)
  );

endmodule

// File: tb/tb_terrain_alpha_shadow_map_decoder.sv
// Testbench for terrain_alpha_shadow_map_decoder: directed and random byte streams in all four
// map formats, checked run by run against a built-in decoder model.
// Depends on tasm_pkg, tasm_ifs and the decoder RTL.
`timescale 1ns / 1ps

module tb_terrain_alpha_shadow_map_decoder;
  import tasm_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned SETTLE       = 16;
  localparam int unsigned RANDOM_BEATS = 100;

  logic clk_i;
  logic rst_ni;

  tasm_in_if  in_if ();
  tasm_cfg_if cfg_if ();
  tasm_out_if out_if ();

  terrain_alpha_shadow_map_decoder i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .cfg_i  (cfg_if),
    .out_o  (out_if)
  );

  // decoder model state
  fmt_e        cur_fmt;
  int unsigned map_pos;
  bit          awaiting_header;
  bit          fill_run;
  logic [6:0]  owed_count;
  res_t        batch[8];
  int          batch_n;

  res_t        runs_due[$];
  int unsigned mismatches;
  int unsigned live_beats;
  int unsigned cycles;
  bit          tx_steady;
  bit          rx_steady;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic int unsigned idle_len(input bit steady);
    int unsigned r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function void emit_run(input logic [7:0] value, input int unsigned len);
    int unsigned take;
    res_t run;
    take = len;
    if (take > MAP_PIXELS - map_pos) take = MAP_PIXELS - map_pos;
    if (take == 0) return;
    run.pixel_index = map_pos[IDX_W-1:0];
    run.pixel_value = value;
    run.run_length  = take[6:0];
    map_pos         = map_pos + take;
    run.map_done    = (map_pos >= MAP_PIXELS);
    run.last_result = 1'b0;
    batch[batch_n]  = run;
    batch_n++;
  endfunction

  // returns 1 when the byte lands inside an unfinished map
  function bit decode_byte(input logic [7:0] b, input logic restart);
    batch_n = 0;
    if (restart) begin
      map_pos         = 0;
      awaiting_header = 1'b1;
      fill_run        = 1'b0;
      owed_count      = '0;
    end
    if (map_pos >= MAP_PIXELS) return 1'b0;
    case (cur_fmt)
      FMT_RLE: begin
        if (awaiting_header) begin
          if ((b & COUNT_MASK) != 0 || (b & FILL_FLAG) != 0) begin
            fill_run        = (b & FILL_FLAG) != 0;
            owed_count      = b[6:0] & COUNT_MASK[6:0];
            awaiting_header = 1'b0;
          end
        end else if (fill_run) begin
          emit_run(b, owed_count);
          owed_count      = '0;
          awaiting_header = 1'b1;
        end else begin
          emit_run(b, 1);
          owed_count = owed_count - 7'd1;
          if (owed_count == 0) awaiting_header = 1'b1;
        end
      end
      FMT_RAW: emit_run(b, 1);
      FMT_NIBBLE: begin
        emit_run(8'd17 * b[3:0], 1);
        emit_run(8'd17 * b[7:4], 1);
      end
      default: begin
        for (int i = 0; i < 8; i++) emit_run(b[i] ? SHADOW_SET : 8'd0, 1);
      end
    endcase
    if (batch_n > 0) batch[batch_n-1].last_result = 1'b1;
    for (int i = 0; i < batch_n; i++) runs_due.push_back(batch[i]);
    return 1'b1;
  endfunction

  task automatic send_beat(input logic [7:0] b, input logic restart);
    int unsigned gap;
    gap = idle_len(tx_steady);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.valid   <= 1'b1;
    in_if.in_byte <= b;
    in_if.new_map <= restart;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    if (decode_byte(b, restart)) live_beats++;
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    while (runs_due.size() != 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  task automatic write_format(input fmt_e fmt);
    drain();
    cfg_if.valid      <= 1'b1;
    cfg_if.map_format <= fmt;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    cur_fmt = fmt;
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic send_fill(input logic [6:0] count, input logic [7:0] value);
    send_beat({1'b1, count}, 1'b0);
    send_beat(value, 1'b0);
  endtask

  task automatic send_copy(input logic [6:0] count);
    send_beat({1'b0, count}, 1'b0);
    repeat (count) send_beat(8'($urandom_range(0, 255)), 1'b0);
  endtask

  // run-length corner cases, format switches in the middle of a map
  task automatic test_directed();
    tx_steady = 1'b0;
    rx_steady = 1'b0;
    send_beat(8'hFF, 1'b1);
    send_beat(8'h00, 1'b0);
    send_beat(8'h02, 1'b0);
    send_beat(8'hFF, 1'b0);
    send_beat(8'h80, 1'b0);
    send_beat(8'h00, 1'b0);
    send_beat(8'h80, 1'b0);
    send_beat(8'h7F, 1'b0);
    send_beat(8'h01, 1'b0);
    send_beat(8'hAA, 1'b0);
    send_beat(8'h85, 1'b0);
    write_format(FMT_RAW);
    send_beat(8'h00, 1'b0);
    send_beat(8'hFF, 1'b0);
    write_format(FMT_NIBBLE);
    send_beat(8'hF0, 1'b0);
    send_beat(8'h0F, 1'b0);
    send_beat(8'hFF, 1'b0);
    write_format(FMT_SHADOW);
    send_beat(8'hA5, 1'b0);
    send_beat(8'h00, 1'b0);
    send_beat(8'hFF, 1'b0);
    write_format(FMT_RLE);
    send_beat(8'h33, 1'b0);
  endtask

  // fill the map to the end, check bytes after it are dropped, then restart
  task automatic test_map_end();
    tx_steady = ($urandom_range(0, 1) == 0);
    rx_steady = ($urandom_range(0, 1) == 0);
    write_format(FMT_RLE);
    send_beat(8'hFF, 1'b1);
    send_beat(8'($urandom_range(0, 255)), 1'b0);
    while (map_pos < MAP_PIXELS) send_fill(7'($urandom_range(90, 127)), 8'($urandom_range(0, 255)));
    repeat (3) send_beat(8'($urandom_range(0, 255)), 1'b0);
    write_format(FMT_SHADOW);
    send_beat(8'hFF, 1'b0);
    send_beat(8'hC3, 1'b1);
  endtask

  task automatic rle_phase(input int unsigned seqs);
    int unsigned r;
    repeat (seqs) begin
      r = $urandom_range(0, 99);
      if (r < 45) begin
        case ($urandom_range(0, 3))
          0:       send_fill(7'd127, 8'($urandom_range(0, 255)));
          1:       send_fill(7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)));
          default: send_fill(7'($urandom_range(1, 8)), 8'($urandom_range(0, 255)));
        endcase
      end else if (r < 80) begin
        send_copy(7'($urandom_range(1, 5)));
      end else if (r < 88) begin
        if ($urandom_range(0, 1) == 0) begin
          send_beat(8'h00, 1'b0);
        end else begin
          send_fill(7'd0, 8'($urandom_range(0, 255)));
        end
      end else begin
        send_beat(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
      end
    end
  endtask

  task automatic test_random();
    int unsigned target;
    int unsigned phase;
    fmt_e fmt;
    target = live_beats + RANDOM_BEATS;
    phase  = 0;
    while (live_beats < target) begin
      case (phase)
        0:       fmt = FMT_RLE;
        1:       fmt = FMT_SHADOW;
        2:       fmt = FMT_RAW;
        3:       fmt = FMT_NIBBLE;
        default: fmt = ($urandom_range(0, 1) == 0) ? FMT_RLE : fmt_e'($urandom_range(1, 3));
      endcase
      tx_steady = ($urandom_range(0, 3) == 0);
      rx_steady = ($urandom_range(0, 3) == 0);
      write_format(fmt);
      if (fmt == FMT_RLE) begin
        rle_phase($urandom_range(5, 12));
      end else begin
        repeat ($urandom_range(8, 20))
          send_beat(8'($urandom_range(0, 255)), $urandom_range(0, 19) == 0);
      end
      phase++;
    end
  endtask

  initial begin : stimulus
    cur_fmt         = FMT_RLE;
    map_pos         = 0;
    awaiting_header = 1'b1;
    fill_run        = 1'b0;
    owed_count      = '0;
    mismatches      = 0;
    live_beats      = 0;
    tx_steady       = 1'b0;
    rx_steady       = 1'b0;
    rst_ni            <= 1'b0;
    in_if.valid       <= 1'b0;
    in_if.in_byte     <= '0;
    in_if.new_map     <= 1'b0;
    cfg_if.valid      <= 1'b0;
    cfg_if.map_format <= FMT_RLE;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    test_map_end();
    test_random();
    in_if.valid <= 1'b0;
    while (runs_due.size() != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin : sink_ready
    int unsigned hold;
    hold = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold > 0) begin
        out_if.ready <= 1'b0;
        hold--;
      end else begin
        out_if.ready <= 1'b1;
        hold = idle_len(rx_steady);
      end
    end
  end

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin : run_check
    res_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (runs_due.size() == 0) begin
        $error("run beat with none due: pixel_index %0d", out_if.pixel_index);
        mismatches++;
      end else begin
        want = runs_due.pop_front();
        check_field("pixel_index", want.pixel_index, out_if.pixel_index);
        check_field("pixel_value", want.pixel_value, out_if.pixel_value);
        check_field("run_length", want.run_length, out_if.run_length);
        check_field("map_done", want.map_done, out_if.map_done);
        check_field("last_result", want.last_result, out_if.last_result);
      end
    end
  end

  initial cycles = 0;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/tasm_pkg.sv
hw/rtl/tasm_ifs.sv
hw/rtl/tasm_front.sv
hw/rtl/tasm_queue.sv
hw/rtl/tasm_back.sv
hw/rtl/terrain_alpha_shadow_map_decoder.sv
tb/tb_terrain_alpha_shadow_map_decoder.sv
